/* src/rrdt_pkg.sv */
`default_nettype none

package rrdt_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int TIME_WIDTH_DEF = 16;
	localparam int INERTIA_W = 16;
	localparam logic [INERTIA_W-1:0] INERTIA_RESET = 16'd800;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W = 4;

	// Command kinds as they arrive on the input word.
	localparam logic [2:0] KIND_TICK = 3'd0;
	localparam logic [2:0] KIND_FWD  = 3'd1;
	localparam logic [2:0] KIND_REV  = 3'd2;
	localparam logic [2:0] KIND_STOP = 3'd3;
	localparam logic [2:0] KIND_FLIP = 3'd4;

	typedef enum logic [2:0] {
		MODE_FREE     = 3'd0,
		MODE_STOPPED  = 3'd1,
		MODE_FWD      = 3'd2,
		MODE_REV      = 3'd3,
		MODE_FWD_PEND = 3'd4,
		MODE_REV_PEND = 3'd5
	} mode_t;

	// Shared by last direction and pending command.
	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_FWD  = 2'd1,
		CMD_REV  = 2'd2,
		CMD_FREE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] channel;
		logic       all_channels;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0] out_channel;
		logic [2:0] chan_state;
		logic       drive_a;
		logic       drive_b;
		logic       flipped;
		logic       last;
	} rsp_word_t;

	typedef struct packed {
		mode_t                mode;
		cmd_t                 last_dir;
		cmd_t                 pend;
		logic                 swap;
		logic [INERTIA_W-1:0] countdown;
		logic                 drive_a;
		logic                 drive_b;
	} chan_t;

endpackage

`default_nettype wire

/* src/reversing_relay_dead_time_controller_top.sv */
// Flow: a command visits each of its channels in turn in the shared update unit (S_WALK),
// then S_EMIT scans the change marks and sends a word for each marked channel that it meets.
// A tick or an all-channel command visits all channels; a single-channel command visits one.
// An output stall holds the scan. Unused kinds and absent channels are taken and dropped.
// No overlap of items: the input stalls until the scan of the last command is over.
// Reset is asynchronous: all channels stopped and idle, dead time 800 ticks, no clear pass.
`default_nettype none

module reversing_relay_dead_time_controller_top #(
	parameter int CHANNELS   = rrdt_pkg::CHANNELS_DEF,
	parameter int TIME_WIDTH = rrdt_pkg::TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrdt_pkg::INERTIA_W-1:0] cfg_data,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  rrdt_pkg::cmd_word_t            cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output rrdt_pkg::rsp_word_t            rsp
);
	import rrdt_pkg::*;

	logic [INERTIA_W-1:0] inertia_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q <= INERTIA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			inertia_q <= cfg_data;
		end
	end

	rrdt_ctrl #(
		.CHANNELS  (CHANNELS),
		.TIME_WIDTH(TIME_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.inertia  (inertia_q),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// A tick always visits every channel, so the block must be busy right after one.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.kind == KIND_TICK |=> cmd_stall)
		else $error("tick word accepted without starting a channel walk");

	a_lines_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.drive_a && rsp.drive_b))
		else $error("both relay lines driven on one channel");

	a_stopped_dark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.chan_state == MODE_STOPPED |-> !rsp.drive_a && !rsp.drive_b)
		else $error("stopped channel reports a driven relay line");

	a_running_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.chan_state == MODE_FWD || rsp.chan_state == MODE_REV)
		|-> rsp.drive_a != rsp.drive_b)
		else $error("running channel does not drive exactly one line");

endmodule

`default_nettype wire

/* src/rrdt_chan_unit.sv */
`default_nettype none

module rrdt_chan_unit #(
	parameter int TIME_WIDTH = rrdt_pkg::TIME_WIDTH_DEF
) (
	input  logic [2:0]                     kind,
	input  logic [rrdt_pkg::INERTIA_W-1:0] inertia,
	input  rrdt_pkg::chan_t                cur,
	input  logic [TIME_WIDTH-1:0]          cur_since,
	output rrdt_pkg::chan_t                nxt,
	output logic [TIME_WIDTH-1:0]          nxt_since,
	output logic                           changed
);
	import rrdt_pkg::*;

	localparam int SW = (TIME_WIDTH > INERTIA_W) ? TIME_WIDTH : INERTIA_W;

	logic [INERTIA_W-1:0] dead;
	logic [INERTIA_W-1:0] cd_dec;
	logic [SW-1:0]        since_ext;
	logic [SW-1:0]        dead_ext;
	logic [SW-1:0]        remain;
	logic                 dead_passed;
	logic                 has_run;
	cmd_t                 dir;

	function automatic chan_t run_dir(chan_t s, cmd_t d);
		chan_t r;
		r = s;
		r.drive_a = s.swap ? (d == CMD_REV) : (d == CMD_FWD);
		r.drive_b = s.swap ? (d == CMD_FWD) : (d == CMD_REV);
		r.last_dir = d;
		r.mode = (d == CMD_FWD) ? MODE_FWD : MODE_REV;
		return r;
	endfunction

	function automatic chan_t stop_ch(chan_t s, logic [INERTIA_W-1:0] dt);
		chan_t r;
		r = s;
		r.drive_a = 1'b0;
		r.drive_b = 1'b0;
		r.mode = MODE_STOPPED;
		r.pend = CMD_NONE;
		r.countdown = '0;
		if (s.last_dir == CMD_FWD || s.last_dir == CMD_REV) begin
			r.pend = CMD_FREE;
			r.countdown = dt;
		end else begin
			r.mode = MODE_FREE;
		end
		return r;
	endfunction

	function automatic chan_t flip_ch(chan_t s, logic [INERTIA_W-1:0] dt);
		chan_t r;
		r = s;
		r.swap = ~s.swap;
		r.pend = CMD_FREE;
		r.countdown = dt;
		return r;
	endfunction

	assign dead = (inertia == '0) ? INERTIA_W'(1) : inertia;
	assign cd_dec = cur.countdown - 1'b1;
	assign since_ext = SW'(cur_since);
	assign dead_ext = SW'(dead);
	assign remain = dead_ext - since_ext;
	assign dead_passed = (since_ext >= dead_ext);
	assign has_run = (cur.last_dir == CMD_FWD) || (cur.last_dir == CMD_REV);
	assign dir = (kind == KIND_REV) ? CMD_REV : CMD_FWD;

	always_comb begin
		nxt = cur;
		nxt_since = cur_since;
		case (kind) inside
			KIND_TICK: begin
				if (cur_since != '1)
					nxt_since = cur_since + 1'b1;
				if (cur.countdown != '0) begin
					nxt.countdown = cd_dec;
					if (cd_dec == '0) begin
						nxt.pend = CMD_NONE;
						case (cur.pend) inside
							CMD_FWD, CMD_REV: nxt = run_dir(nxt, cur.pend);
							CMD_FREE: nxt.mode = MODE_FREE;
							default: ;
						endcase
					end
				end
			end
			KIND_STOP: begin
				if (cur.mode != MODE_STOPPED) begin
					nxt = stop_ch(cur, dead);
					if (has_run)
						nxt_since = '0;
				end
			end
			KIND_FWD, KIND_REV, KIND_FLIP: begin
				case (cur.mode) inside
					MODE_FREE: begin
						nxt = (kind == KIND_FLIP) ? flip_ch(cur, dead) : run_dir(cur, dir);
					end
					MODE_STOPPED: begin
						if (kind == KIND_FLIP) begin
							nxt = flip_ch(cur, dead);
						end else if (cur.last_dir == dir || cur.last_dir == CMD_NONE ||
								dead_passed) begin
							nxt = run_dir(cur, dir);
						end else begin
							// Opposite run waits out what is left of the dead time.
							nxt.pend = dir;
							nxt.mode = (dir == CMD_FWD) ? MODE_FWD_PEND : MODE_REV_PEND;
							nxt.countdown = remain[INERTIA_W-1:0];
						end
					end
					MODE_FWD, MODE_REV: begin
						if (kind == KIND_FLIP) begin
							nxt = flip_ch(stop_ch(cur, dead), dead);
							nxt_since = '0;
						end else if (cur.last_dir != dir) begin
							nxt.pend = dir;
							nxt.mode = (dir == CMD_FWD) ? MODE_FWD_PEND : MODE_REV_PEND;
							nxt.countdown = dead;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign changed = (nxt.mode != cur.mode) || (nxt.drive_a != cur.drive_a) ||
		(nxt.drive_b != cur.drive_b) || (nxt.swap != cur.swap);

endmodule

`default_nettype wire

/* src/rrdt_ctrl.sv */
`default_nettype none

module rrdt_ctrl #(
	parameter int CHANNELS   = rrdt_pkg::CHANNELS_DEF,
	parameter int TIME_WIDTH = rrdt_pkg::TIME_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rrdt_pkg::INERTIA_W-1:0] inertia,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  rrdt_pkg::cmd_word_t            cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output rrdt_pkg::rsp_word_t            rsp
);
	import rrdt_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [2:0]           kind_q;
	logic                 single_q;
	logic [CW-1:0]        idx_q;
	logic [CHANNELS-1:0]  changed_q;
	logic [CNT_W-1:0]     sent_q;
	chan_t                st_q [CHANNELS];
	logic [TIME_WIDTH-1:0] ss_q [CHANNELS];
	rsp_word_t            rsp_q;
	logic                 rsp_valid_q;

	chan_t                cur;
	chan_t                nxt;
	logic [TIME_WIDTH-1:0] nxt_since;
	logic                 unit_changed;
	logic                 in_range;
	logic                 kind_ok;
	logic                 rsp_free;
	logic                 more_after;
	logic                 is_last;
	logic                 emit;

	assign cur = st_q[idx_q];
	assign cmd_stall = (state_q != S_IDLE);
	assign in_range = ({2'b00, cmd.channel} < 5'(CHANNELS));
	assign kind_ok = (cmd.kind <= KIND_FLIP);
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign more_after = |((changed_q >> idx_q) >> 1);
	assign is_last = (sent_q == CNT_W'(MAX_RESULTS - 1)) || !more_after;
	assign emit = (state_q == S_EMIT) && changed_q[idx_q] && rsp_free;

	rrdt_chan_unit #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_unit (
		.kind      (kind_q),
		.inertia   (inertia),
		.cur       (cur),
		.cur_since (ss_q[idx_q]),
		.nxt       (nxt),
		.nxt_since (nxt_since),
		.changed   (unit_changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= KIND_TICK;
			single_q <= 1'b0;
			idx_q <= '0;
			changed_q <= '0;
			sent_q <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				st_q[i] <= '{mode: MODE_STOPPED, last_dir: CMD_NONE, pend: CMD_NONE,
					swap: 1'b0, countdown: '0, drive_a: 1'b0, drive_b: 1'b0};
				ss_q[i] <= '0;
			end
		end else begin
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_free)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						kind_q <= cmd.kind;
						changed_q <= '0;
						sent_q <= '0;
						if (cmd.kind == KIND_TICK || (kind_ok && cmd.all_channels)) begin
							idx_q <= '0;
							single_q <= 1'b0;
							state_q <= S_WALK;
						end else if (kind_ok && in_range) begin
							idx_q <= CW'(cmd.channel);
							single_q <= 1'b1;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					st_q[idx_q] <= nxt;
					ss_q[idx_q] <= nxt_since;
					changed_q[idx_q] <= unit_changed;
					if (single_q || idx_q == LAST_CH) begin
						idx_q <= '0;
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					// Scan the change marks; a marked channel waits for a free output word.
					if (changed_q[idx_q]) begin
						if (rsp_free) begin
							rsp_q.out_channel <= 3'(idx_q);
							rsp_q.chan_state <= cur.mode;
							rsp_q.drive_a <= cur.drive_a;
							rsp_q.drive_b <= cur.drive_b;
							rsp_q.flipped <= cur.swap;
							rsp_q.last <= is_last;
							sent_q <= sent_q + 1'b1;
							if (is_last)
								state_q <= S_IDLE;
							else
								idx_q <= idx_q + 1'b1;
						end
					end else if (idx_q == LAST_CH) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrdt_pkg::*;

	localparam int CH = CHANNELS_DEF;
	localparam int SETTLE_CYCLES = 4 + 4 * CH;
	localparam int HOLD_AT = 110;
	localparam int HOLD_CYCLES = 300;

	class relay_scoreboard;
		mode_t               chan_mode [CH];
		cmd_t                chan_last [CH];
		cmd_t                chan_pend [CH];
		bit                  chan_swap [CH];
		bit [15:0]           chan_count [CH];
		bit [15:0]           chan_since [CH];
		bit                  line_a [CH];
		bit                  line_b [CH];
		bit [INERTIA_W-1:0]  inertia;
		rsp_word_t           changes_due [$];
		int                  errors;
		int                  words_in;
		int                  words_out;
		int                  settings;

		function new();
			inertia = INERTIA_RESET;
			errors = 0;
			words_in = 0;
			words_out = 0;
			settings = 1;
			for (int c = 0; c < CH; c++) begin
				chan_mode[c] = MODE_STOPPED;
				chan_last[c] = CMD_NONE;
				chan_pend[c] = CMD_NONE;
				chan_swap[c] = 1'b0;
				chan_count[c] = '0;
				chan_since[c] = '0;
				line_a[c] = 1'b0;
				line_b[c] = 1'b0;
			end
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 50)
				$display("tb: mismatch at %0t: %s", $time, msg);
		endfunction

		function void set_inertia(bit [INERTIA_W-1:0] v);
			inertia = v;
			settings++;
		endfunction

		// A dead time of zero behaves as one tick.
		function bit [15:0] dead_time();
			return (inertia == 0) ? 16'd1 : inertia;
		endfunction

		function void go_free(int c);
			chan_pend[c] = CMD_NONE;
			chan_count[c] = '0;
			chan_mode[c] = MODE_FREE;
		endfunction

		function void go_stop(int c);
			line_a[c] = 1'b0;
			line_b[c] = 1'b0;
			chan_mode[c] = MODE_STOPPED;
			chan_pend[c] = CMD_NONE;
			chan_count[c] = '0;
			if (chan_last[c] != CMD_NONE) begin
				chan_since[c] = '0;
				chan_pend[c] = CMD_FREE;
				chan_count[c] = dead_time();
			end else begin
				go_free(c);
			end
		endfunction

		function void go_run(int c, cmd_t dir);
			bit fwd_on;
			fwd_on = (dir == CMD_FWD);
			line_a[c] = chan_swap[c] ? !fwd_on : fwd_on;
			line_b[c] = chan_swap[c] ? fwd_on : !fwd_on;
			chan_last[c] = dir;
			chan_mode[c] = (dir == CMD_FWD) ? MODE_FWD : MODE_REV;
		endfunction

		function void go_flip(int c);
			chan_swap[c] = !chan_swap[c];
			chan_pend[c] = CMD_FREE;
			chan_count[c] = dead_time();
		endfunction

		function void go_pending(int c, cmd_t dir, bit [15:0] wait_ticks);
			chan_pend[c] = dir;
			chan_mode[c] = (dir == CMD_FWD) ? MODE_FWD_PEND : MODE_REV_PEND;
			chan_count[c] = wait_ticks;
		endfunction

		function void issue(int c, logic [2:0] kind);
			mode_t m;
			cmd_t dir;
			m = chan_mode[c];
			dir = (kind == KIND_FWD) ? CMD_FWD : CMD_REV;
			if (kind == KIND_STOP) begin
				if (m != MODE_STOPPED)
					go_stop(c);
			end else if (m == MODE_FREE) begin
				if (kind == KIND_FLIP)
					go_flip(c);
				else
					go_run(c, dir);
			end else if (m == MODE_STOPPED) begin
				if (kind == KIND_FLIP)
					go_flip(c);
				else if (chan_last[c] == dir || chan_last[c] == CMD_NONE ||
						chan_since[c] >= dead_time())
					go_run(c, dir);
				else
					go_pending(c, dir, dead_time() - chan_since[c]);
			end else if (m == MODE_FWD || m == MODE_REV) begin
				if (kind == KIND_FLIP) begin
					go_stop(c);
					go_flip(c);
				end else if (chan_last[c] != dir) begin
					go_pending(c, dir, dead_time());
				end
			end
		endfunction

		function void tick_chan(int c);
			cmd_t p;
			if (chan_since[c] != 16'hFFFF)
				chan_since[c]++;
			if (chan_count[c] != 0) begin
				chan_count[c]--;
				if (chan_count[c] == 0) begin
					p = chan_pend[c];
					chan_pend[c] = CMD_NONE;
					if (p == CMD_FWD || p == CMD_REV)
						go_run(c, p);
					else if (p == CMD_FREE)
						go_free(c);
				end
			end
		endfunction

		// Applies one accepted command word and queues one result word per
		// channel whose state, lines or mapping moved, in channel order.
		function void note_command(cmd_word_t w);
			mode_t     old_mode [CH];
			bit        old_a [CH];
			bit        old_b [CH];
			bit        old_swap [CH];
			bit        moved [CH];
			int        n;
			int        k;
			rsp_word_t r;
			words_in++;
			if (w.kind > KIND_FLIP)
				return;
			old_mode = chan_mode;
			old_a = line_a;
			old_b = line_b;
			old_swap = chan_swap;
			if (w.kind == KIND_TICK) begin
				for (int c = 0; c < CH; c++)
					tick_chan(c);
			end else if (w.all_channels) begin
				for (int c = 0; c < CH; c++)
					issue(c, w.kind);
			end else if (int'(w.channel) < CH) begin
				issue(w.channel, w.kind);
			end
			n = 0;
			for (int c = 0; c < CH; c++) begin
				moved[c] = old_mode[c] != chan_mode[c] || old_a[c] != line_a[c] ||
					old_b[c] != line_b[c] || old_swap[c] != chan_swap[c];
				if (moved[c] && n < MAX_RESULTS)
					n++;
			end
			k = 0;
			for (int c = 0; c < CH && k < n; c++) begin
				if (moved[c]) begin
					r.out_channel = 3'(c);
					r.chan_state = chan_mode[c];
					r.drive_a = line_a[c];
					r.drive_b = line_b[c];
					r.flipped = chan_swap[c];
					r.last = (k == n - 1);
					changes_due.push_back(r);
					k++;
				end
			end
		endfunction

		function void check_change(rsp_word_t got);
			rsp_word_t want;
			words_out++;
			if (changes_due.size() == 0) begin
				report($sformatf("unexpected result word %h", got));
				return;
			end
			want = changes_due.pop_front();
			if (got.out_channel !== want.out_channel)
				report($sformatf("out_channel %0d, want %0d", got.out_channel, want.out_channel));
			if (got.chan_state !== want.chan_state)
				report($sformatf("chan_state %0d, want %0d (channel %0d)",
					got.chan_state, want.chan_state, want.out_channel));
			if (got.drive_a !== want.drive_a)
				report($sformatf("drive_a %b, want %b (channel %0d)",
					got.drive_a, want.drive_a, want.out_channel));
			if (got.drive_b !== want.drive_b)
				report($sformatf("drive_b %b, want %b (channel %0d)",
					got.drive_b, want.drive_b, want.out_channel));
			if (got.flipped !== want.flipped)
				report($sformatf("flipped %b, want %b (channel %0d)",
					got.flipped, want.flipped, want.out_channel));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b (channel %0d)",
					got.last, want.last, want.out_channel));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [INERTIA_W-1:0] cfg_data;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_word_t            cmd;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_word_t            rsp;

	relay_scoreboard sb;
	int send_pct;
	int stall_pct;
	int hold_left = 0;
	bit hold_done = 1'b0;

	reversing_relay_dead_time_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// Output side: random stall, plus one long hold once enough words have gone in,
	// so the block backs up and stalls its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall = 1'b1;
			hold_left--;
		end else if (!hold_done && sb != null && sb.words_in >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			rsp_stall = 1'b1;
		end else begin
			rsp_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_change(rsp);
	end

	function automatic cmd_word_t cw(logic [2:0] kind, logic [2:0] chan, logic all);
		cmd_word_t w;
		w.kind = kind;
		w.channel = chan;
		w.all_channels = all;
		return w;
	endfunction

	function automatic cmd_word_t random_command();
		cmd_word_t w;
		int r;
		r = $urandom_range(99);
		if (r < 4)
			w.kind = 3'($urandom_range(7, 5));
		else if (r < 45)
			w.kind = KIND_TICK;
		else if (r < 62)
			w.kind = KIND_FWD;
		else if (r < 79)
			w.kind = KIND_REV;
		else if (r < 91)
			w.kind = KIND_STOP;
		else
			w.kind = KIND_FLIP;
		w.channel = 3'($urandom_range(7));
		w.all_channels = ($urandom_range(4) == 0);
		return w;
	endfunction

	// Valid stays high until the word is taken; the gap before it is random.
	task automatic push_cmd(cmd_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd = w;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(w);
	endtask

	task automatic write_inertia(logic [INERTIA_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_inertia(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait for every queued result, then long enough for a word that changed
	// nothing to finish its scan.
	task automatic settle();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (sb.changes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		#5ms;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		cmd_word_t w;
		int counted;
		int items;
		logic [INERTIA_W-1:0] dt;
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_stall = 1'b0;
		send_pct = 0;
		stall_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset dead time: runs, ignored repeats, reversals going pending,
		// all-channel commands, flips, stops and unused kinds.
		push_cmd(cw(KIND_TICK, 3'd7, 1'b1));
		push_cmd(cw(KIND_FWD, 3'd0, 1'b0));
		push_cmd(cw(KIND_FWD, 3'd0, 1'b0));
		push_cmd(cw(KIND_REV, 3'd0, 1'b0));
		push_cmd(cw(KIND_FLIP, 3'd0, 1'b0));
		push_cmd(cw(KIND_STOP, 3'd0, 1'b0));
		push_cmd(cw(KIND_REV, 3'd0, 1'b0));
		push_cmd(cw(KIND_FWD, 3'd0, 1'b1));
		push_cmd(cw(KIND_FLIP, 3'd1, 1'b0));
		push_cmd(cw(KIND_REV, 3'd1, 1'b0));
		push_cmd(cw(KIND_STOP, 3'd0, 1'b1));
		push_cmd(cw(3'd5, 3'd3, 1'b0));
		push_cmd(cw(3'd6, 3'd0, 1'b1));
		push_cmd(cw(3'd7, 3'd7, 1'b1));
		push_cmd(cw(KIND_STOP, 3'd2, 1'b0));
		push_cmd(cw(KIND_FLIP, 3'd3, 1'b0));
		settle();

		// Zero dead time acts as one tick. Channel 0 has been stopped for one
		// tick by then, so its reversal runs at once.
		write_inertia('0);
		push_cmd(cw(KIND_TICK, 3'd7, 1'b1));
		push_cmd(cw(KIND_REV, 3'd0, 1'b0));
		push_cmd(cw(KIND_FWD, 3'd3, 1'b0));
		push_cmd(cw(KIND_REV, 3'd3, 1'b0));
		push_cmd(cw(KIND_TICK, 3'd0, 1'b0));
		push_cmd(cw(KIND_FLIP, 3'd3, 1'b0));
		push_cmd(cw(KIND_TICK, 3'd5, 1'b0));
		push_cmd(cw(KIND_FLIP, 3'd3, 1'b0));
		push_cmd(cw(KIND_REV, 3'd3, 1'b0));
		settle();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin send_pct = 0;  stall_pct = 0;  dt = 16'd1;     items = 30; end
				1: begin send_pct = 45; stall_pct = 0;  dt = 16'd5;     items = 30; end
				2: begin send_pct = 0;  stall_pct = 45; dt = 16'hFFFF;  items = 20; end
				3: begin
					send_pct = 15;
					stall_pct = 15;
					dt = 16'($urandom_range(9, 2));
					items = 35;
				end
				default: begin send_pct = 0; stall_pct = 0; dt = 16'd2; items = 25; end
			endcase
			write_inertia(dt);
			counted = 0;
			while (counted < items) begin
				w = random_command();
				push_cmd(w);
				if (w.kind <= KIND_FLIP)
					counted++;
			end
			settle();
		end

		$display("tb: %0d command words taken, %0d result words checked",
			sb.words_in, sb.words_out);
		$display("tb: %0d dead-time settings, idle and stall mixes, one long output hold",
			sb.settings);
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
